// ===== src/q24alu_pkg.sv =====
`default_nettype none

package q24alu_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int WORD_W = 32;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_RANGE   = 2'd1;
   localparam logic [1:0] STAT_DIVZERO = 2'd2;

   typedef struct packed {
      logic        ovf;
      logic [31:0] val;
   } fit_type;

   // Applies a sign to a magnitude and checks that the value fits in 32 signed bits.
   function automatic fit_type fit_signed(input logic [63:0] mag, input logic neg);
      fit_type     f;
      logic [63:0] neg_mag;
      neg_mag = ~mag + 64'd1;
      f.val = neg ? neg_mag[31:0] : mag[31:0];
      f.ovf = neg ? (mag > 64'h0000_0000_8000_0000) : (mag > 64'h0000_0000_7FFF_FFFF);
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== src/q24_8_fixed_point_alu_core.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | func, operand_a, operand_b
// rsp     | out       | rsp_valid/rsp_stall  | result_value, compare_true, status
//
// One beat enters per cycle while no rsp beat is held; every beat crosses the whole pipeline to reach rsp.
// The pipeline depth is set by the divider, which resolves one quotient bit per stage.
// All operations travel the same pipeline, so beats leave in arrival order.
// Reset clears the valid bits only. A stalled rsp beat freezes the whole pipeline.

module q24_8_fixed_point_alu_core
   import q24alu_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_func,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_result_value,
   output logic                    rsp_compare_true,
   output logic [1:0]              rsp_status
);

   localparam int DW = WORD_W + FRAC_BITS;
   localparam int L  = DW + 2;

   logic              vld_ff  [L];
   logic              vld_in  [L];
   op_type            func_ff [L];
   op_type            func_in [L];
   logic [31:0]       res_ff  [L];
   logic [31:0]       res_in  [L];
   logic              cmp_ff  [L];
   logic              cmp_in  [L];
   logic [1:0]        stat_ff [L];
   logic [1:0]        stat_in [L];
   logic              neg_ff  [L];
   logic              neg_in  [L];
   logic              dz_ff   [L];
   logic              dz_in   [L];
   logic [31:0]       dvs_ff  [L];
   logic [31:0]       dvs_in  [L];
   logic [31:0]       rem_ff  [L];
   logic [31:0]       rem_in  [L];
   logic [DW-1:0]     work_ff [L];
   logic [DW-1:0]     work_in [L];
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   logic        en;
   logic [31:0] mag_a;
   logic [31:0] mag_b;
   logic [32:0] sum33;
   logic [32:0] dif33;
   logic [32:0] inc33;
   logic [32:0] dec33;
   logic [31:0] shr_a;
   logic [31:0] neg_shr_a;
   fit_type     fint;
   fit_type     fmul;
   fit_type     fdiv;
   logic [63:0] pmag;
   logic [63:0] pneg;
   logic [32:0] sh   [L];
   logic [32:0] diff [L];
   logic        ge   [L];

   assign en        = !(vld_ff[L-1] && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      mag_a     = req_operand_a[31] ? (~req_operand_a + 32'd1) : req_operand_a;
      mag_b     = req_operand_b[31] ? (~req_operand_b + 32'd1) : req_operand_b;
      sum33     = {req_operand_a[31], req_operand_a} + {req_operand_b[31], req_operand_b};
      dif33     = {req_operand_a[31], req_operand_a} - {req_operand_b[31], req_operand_b};
      inc33     = {req_operand_a[31], req_operand_a} + 33'd1;
      dec33     = {req_operand_a[31], req_operand_a} - 33'd1;
      shr_a     = mag_a >> FRAC_BITS;
      neg_shr_a = ~shr_a + 32'd1;
      fint      = fit_signed(64'({mag_a, {FRAC_BITS{1'b0}}}), req_operand_a[31]);
      prod_in   = 64'(req_operand_a) * 64'(req_operand_b);

      vld_in[0]  = req_valid;
      func_in[0] = op_type'(req_func);
      res_in[0]  = '0;
      cmp_in[0]  = 1'b0;
      stat_in[0] = STAT_OK;
      neg_in[0]  = req_operand_a[31] ^ req_operand_b[31];
      dz_in[0]   = (req_operand_b == 32'sd0);
      dvs_in[0]  = mag_b;
      rem_in[0]  = '0;
      work_in[0] = {mag_a, {FRAC_BITS{1'b0}}};
      unique case (op_type'(req_func))
         OP_ADD: begin
            res_in[0]  = sum33[31:0];
            stat_in[0] = (sum33[32] != sum33[31]) ? STAT_RANGE : STAT_OK;
         end
         OP_SUB: begin
            res_in[0]  = dif33[31:0];
            stat_in[0] = (dif33[32] != dif33[31]) ? STAT_RANGE : STAT_OK;
         end
         OP_MUL: begin
         end
         OP_DIV: begin
            stat_in[0] = (req_operand_b == 32'sd0) ? STAT_DIVZERO : STAT_OK;
         end
         OP_GT: cmp_in[0] = req_operand_a > req_operand_b;
         OP_LT: cmp_in[0] = req_operand_a < req_operand_b;
         OP_GE: cmp_in[0] = req_operand_a >= req_operand_b;
         OP_LE: cmp_in[0] = req_operand_a <= req_operand_b;
         OP_EQ: cmp_in[0] = req_operand_a == req_operand_b;
         OP_NE: cmp_in[0] = req_operand_a != req_operand_b;
         OP_MIN: res_in[0] = (req_operand_a < req_operand_b) ? req_operand_a : req_operand_b;
         OP_MAX: res_in[0] = (req_operand_a > req_operand_b) ? req_operand_a : req_operand_b;
         OP_INC: begin
            res_in[0]  = inc33[31:0];
            stat_in[0] = (inc33[32] != inc33[31]) ? STAT_RANGE : STAT_OK;
         end
         OP_DEC: begin
            res_in[0]  = dec33[31:0];
            stat_in[0] = (dec33[32] != dec33[31]) ? STAT_RANGE : STAT_OK;
         end
         OP_FROM_INT: begin
            res_in[0]  = fint.val;
            stat_in[0] = fint.ovf ? STAT_RANGE : STAT_OK;
         end
         OP_TO_INT: res_in[0] = req_operand_a[31] ? neg_shr_a : shr_a;
         default: ;
      endcase

      pneg = ~prod_ff + 64'd1;
      pmag = prod_ff[63] ? pneg : prod_ff;
      fmul = fit_signed(pmag >> FRAC_BITS, prod_ff[63]);

      for (int k = 1; k < L; k++) begin
         vld_in[k]  = vld_ff[k-1];
         func_in[k] = func_ff[k-1];
         res_in[k]  = res_ff[k-1];
         cmp_in[k]  = cmp_ff[k-1];
         stat_in[k] = stat_ff[k-1];
         neg_in[k]  = neg_ff[k-1];
         dz_in[k]   = dz_ff[k-1];
         dvs_in[k]  = dvs_ff[k-1];
         sh[k]      = {rem_ff[k-1], work_ff[k-1][DW-1]};
         diff[k]    = sh[k] - {1'b0, dvs_ff[k-1]};
         ge[k]      = sh[k] >= {1'b0, dvs_ff[k-1]};
         if (k <= DW) begin
            rem_in[k]  = ge[k] ? diff[k][31:0] : sh[k][31:0];
            work_in[k] = {work_ff[k-1][DW-2:0], ge[k]};
         end else begin
            rem_in[k]  = rem_ff[k-1];
            work_in[k] = work_ff[k-1];
         end
      end
      sh[0]   = '0;
      diff[0] = '0;
      ge[0]   = 1'b0;

      if (func_ff[0] == OP_MUL) begin
         res_in[1]  = fmul.val;
         stat_in[1] = fmul.ovf ? STAT_RANGE : STAT_OK;
      end

      fdiv = fit_signed(64'(work_ff[L-2]), neg_ff[L-2]);
      if (func_ff[L-2] == OP_DIV && !dz_ff[L-2]) begin
         res_in[L-1]  = fdiv.val;
         stat_in[L-1] = fdiv.ovf ? STAT_RANGE : STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         for (int k = 0; k < L; k++) begin
            func_ff[k] <= func_in[k];
            res_ff[k]  <= res_in[k];
            cmp_ff[k]  <= cmp_in[k];
            stat_ff[k] <= stat_in[k];
            neg_ff[k]  <= neg_in[k];
            dz_ff[k]   <= dz_in[k];
            dvs_ff[k]  <= dvs_in[k];
            rem_ff[k]  <= rem_in[k];
            work_ff[k] <= work_in[k];
         end
      end
      for (int k = 0; k < L; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   assign rsp_valid        = vld_ff[L-1];
   assign rsp_result_value = res_ff[L-1];
   assign rsp_compare_true = cmp_ff[L-1];
   assign rsp_status       = stat_ff[L-1];

endmodule

`default_nettype wire

// ===== src/q24alu_checker.sv =====
`default_nettype none

module q24alu_checker
   import q24alu_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_result_value,
   input wire logic        rsp_compare_true,
   input wire logic [1:0]  rsp_status
);

   // A held result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status) && $stable(rsp_compare_true))
      else $error("held rsp beat changed");

   // The input side only stalls behind a held result beat.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a held rsp beat");

   // A comparison outcome carries a zero value and a clean status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_result_value == 32'd0 && rsp_status == STAT_OK)
      else $error("comparison beat with value or status");

   // Division by zero returns zero and never a code outside the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3
         && (rsp_status != STAT_DIVZERO || rsp_result_value == 32'd0))
      else $error("bad status or divide-by-zero value");

endmodule

bind q24_8_fixed_point_alu_core q24alu_checker u_q24alu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value),
   .rsp_compare_true (rsp_compare_true),
   .rsp_status       (rsp_status)
);

`default_nettype wire
